// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the 3x3 convolution block.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define C2D_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define C2D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define C2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define C2D_ASSERT(lbl, clk, rstn, prop, msg)
`define C2D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define C2D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/c2d_pkg.sv =====
// Package of the 3x3 convolution block: constants, register indexes, cell control.
// No dependencies.
`timescale 1ns / 1ps

package c2d_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_PIXEL_BITS  = 16;
    localparam int DEF_COEF_BITS   = 16;

    localparam int KSIZE           = 3;    // kernel rows, columns and cells
    localparam int TAP_SLOT        = 16;   // tap pitch in a coefficient register
    localparam int SUM_BITS        = 35;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int COEF_REG_BITS   = 48;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 48;

    localparam int RESET_WIDTH     = 6;
    localparam int RESET_HEIGHT    = 6;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_ROW0    = 3'd2,
        REG_COEF_ROW1    = 3'd3,
        REG_COEF_ROW2    = 3'd4
    } c2d_reg_t;

    // shift: a new column enters the window; step: product/sum pipeline moves
    typedef struct packed {
        logic shift;
        logic step;
    } c2d_cell_ctrl_t;

endpackage

// ===== hw/rtl/c2d_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps

module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/c2d_cell.sv =====
// One window column cell: holds a 3-pixel column, hands it to its neighbor,
// forms three registered products and their registered column sum. Uses c2d_pkg.
`timescale 1ns / 1ps

module c2d_cell #(
    parameter int PIXEL_BITS = c2d_pkg::DEF_PIXEL_BITS,
    parameter int COEF_BITS  = c2d_pkg::DEF_COEF_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  c2d_pkg::c2d_cell_ctrl_t                ctrl,
    input  logic [c2d_pkg::KSIZE*PIXEL_BITS-1:0]   col_in,   // row 0 in low bits
    input  logic [c2d_pkg::KSIZE*COEF_BITS-1:0]    taps,     // row 0 in low bits
    output logic [c2d_pkg::KSIZE*PIXEL_BITS-1:0]   col_out,
    output logic signed [c2d_pkg::SUM_BITS-1:0]    col_sum
);

    import c2d_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;

    logic [KSIZE*PIXEL_BITS-1:0]  col_reg;
    logic signed [PROD_BITS-1:0]  prod_reg  [KSIZE];
    logic signed [PROD_BITS-1:0]  prod_next [KSIZE];
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic signed [SUM_BITS-1:0]   sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (ctrl.shift) begin
            col_reg <= col_in;
        end
    end

    always_comb begin
        for (int k = 0; k < KSIZE; k++) begin
            prod_next[k] = $signed(col_reg[k*PIXEL_BITS +: PIXEL_BITS])
                         * $signed(taps[k*COEF_BITS +: COEF_BITS]);
        end
    end

    // sum wraps at SUM_BITS, which is exact for the field's range
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < KSIZE; k++) begin
            sum_next = sum_next + SUM_BITS'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            for (int k = 0; k < KSIZE; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

// ===== hw/rtl/conv2d_3x3_valid_stream_unit.sv =====
// Top level of the streaming 3x3 valid convolution (stride 1, no padding, no flip).
// Depends on c2d_pkg, c2d_ram, c2d_cell and assert_macros.svh.
//
// Usage:
//   s_ channel: one pixel item per handshake, row-major raster order. s_tdata holds
//   the signed pixel, s_tuser marks the first pixel of a frame (resets row/column).
//   m_ channel: one item per full 3x3 window, i.e. at row >= 2 and column >= 2.
//   m_tdata holds the exact signed window sum, m_tlast flags the frame's last one.
//   cfg_ port: write-only registers (width, height, three kernel rows); write them
//   only while no item is in flight.
// Throughput: one pixel per clock, sustained while the output is not stalled. Every
//   pixel moves through a fixed five-register pipeline: row store read, window cell,
//   products, column sums, output register.
// Stall: while m_tvalid is high and m_tready low the whole pipeline freezes and
//   s_tready drops; nothing is lost or repeated.
// Reset: synchronous, active low. Row/column counters clear, width and height
//   return to 6, taps to 0. The row stores have no init; entries are always
//   written within a frame before being read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module conv2d_3x3_valid_stream_unit #(
    parameter int MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = c2d_pkg::DEF_PIXEL_BITS,
    parameter int COEF_BITS  = c2d_pkg::DEF_COEF_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [c2d_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [c2d_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
    // pixel input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,   // [PIXEL_BITS-1:0] pixel
    input  logic                                 s_tuser,   // [0] frame_start
    // window result
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((c2d_pkg::SUM_BITS+7)/8)*8-1:0] m_tdata, // [34:0] conv_sum
    output logic                                 m_tlast    // frame_last
);

    import c2d_pkg::*;

    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int M_DATA_BITS  = ((SUM_BITS + 7) / 8) * 8;
    localparam int COEF_EXT     = TAP_SLOT * (KSIZE - 1) + COEF_BITS;
    localparam int COL_VEC_BITS = KSIZE * PIXEL_BITS;

    // ---------------- configuration registers ----------------
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;
    logic [COEF_REG_BITS-1:0]   coef_reg [KSIZE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_REG_BITS'(RESET_WIDTH);
            height_reg <= HEIGHT_REG_BITS'(RESET_HEIGHT);
            for (int k = 0; k < KSIZE; k++) begin
                coef_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (c2d_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg   <= cfg_wr_data[WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_wr_data[HEIGHT_REG_BITS-1:0];
                REG_COEF_ROW0:    coef_reg[0] <= cfg_wr_data[COEF_REG_BITS-1:0];
                REG_COEF_ROW1:    coef_reg[1] <= cfg_wr_data[COEF_REG_BITS-1:0];
                REG_COEF_ROW2:    coef_reg[2] <= cfg_wr_data[COEF_REG_BITS-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // effective geometry, minus one: width clamped to [3, MAX_WIDTH], height to >= 3
    logic [COL_BITS-1:0]        w_m1;
    logic [HEIGHT_REG_BITS-1:0] h_m1;

    always_comb begin
        if (32'(width_reg) < KSIZE) begin
            w_m1 = COL_BITS'(KSIZE - 1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_m1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_m1 = COL_BITS'(width_reg - WIDTH_REG_BITS'(1));
        end
        if (32'(height_reg) < KSIZE) begin
            h_m1 = HEIGHT_REG_BITS'(KSIZE - 1);
        end else begin
            h_m1 = height_reg - HEIGHT_REG_BITS'(1);
        end
    end

    // ---------------- handshake ----------------
    // One global step: the pipeline moves whenever the output slot is free or drains.
    logic advance;
    logic in_accept;

    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign in_accept = s_tvalid && advance;

    // ---------------- raster position ----------------
    logic [COL_BITS-1:0]        col_reg, col_next, col_acc;
    logic [HEIGHT_REG_BITS-1:0] row_reg, row_next, row_acc;
    logic                       line_end, frame_end, acc_emit;

    always_comb begin
        col_acc   = s_tuser ? '0 : col_reg;
        row_acc   = s_tuser ? '0 : row_reg;
        line_end  = col_acc >= w_m1;
        frame_end = row_acc >= h_m1;
        acc_emit  = (32'(row_acc) >= KSIZE - 1) && (32'(col_acc) >= KSIZE - 1);
        col_next  = col_reg;
        row_next  = row_reg;
        if (in_accept) begin
            if (line_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_acc + HEIGHT_REG_BITS'(1);
            end else begin
                col_next = col_acc + COL_BITS'(1);
                row_next = row_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: row store read ----------------
    logic                   s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [COL_BITS-1:0]    s1_col_reg;
    logic [PIXEL_BITS-1:0]  s1_bot_reg;
    logic [PIXEL_BITS-1:0]  older_q, newer_q;
    logic [PIXEL_BITS-1:0]  cur_top, cur_mid;
    logic                   wr_en;
    // bypass for a read of the address being written in the same cycle
    // (frame_start right after a column-0 pixel)
    logic                   byp_reg;
    logic [PIXEL_BITS-1:0]  byp_top_reg, byp_mid_reg;

    assign wr_en   = advance && s1_valid_reg;
    assign cur_top = byp_reg ? byp_top_reg : older_q;
    assign cur_mid = byp_reg ? byp_mid_reg : newer_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else begin
            if (advance) begin
                s1_valid_reg <= in_accept;
            end
            if (in_accept) begin
                byp_reg <= wr_en && (s1_col_reg == col_acc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_emit_reg <= acc_emit;
            s1_last_reg <= acc_emit && line_end && frame_end;
            s1_col_reg  <= col_acc;
            s1_bot_reg  <= s_tdata[PIXEL_BITS-1:0];
            byp_top_reg <= cur_mid;
            byp_mid_reg <= s1_bot_reg;
        end
    end

    // two rows back
    c2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_older (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (cur_mid),
        .rd_en   (in_accept),
        .rd_addr (col_acc),
        .rd_data (older_q)
    );

    // one row back
    c2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_newer (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (s1_bot_reg),
        .rd_en   (in_accept),
        .rd_addr (col_acc),
        .rd_data (newer_q)
    );

    // ---------------- window cells ----------------
    // cell KSIZE-1 takes the fresh column; each cell hands its column to the left.
    // After a shift, cell i holds column col-(KSIZE-1)+i and multiplies by tap i.
    c2d_cell_ctrl_t              cell_ctrl;
    logic [COL_VEC_BITS-1:0]     cur_col;
    logic [COL_VEC_BITS-1:0]     col_link  [KSIZE];
    logic [KSIZE*COEF_BITS-1:0]  cell_taps [KSIZE];
    logic signed [SUM_BITS-1:0]  col_sum   [KSIZE];
    logic [COEF_EXT-1:0]         coef_ext  [KSIZE];

    assign cell_ctrl.shift = advance && s1_valid_reg;
    assign cell_ctrl.step  = advance;
    assign cur_col         = {s1_bot_reg, cur_mid, cur_top};

    for (genvar k = 0; k < KSIZE; k++) begin : g_coef
        assign coef_ext[k] = COEF_EXT'(coef_reg[k]);
    end

    for (genvar i = 0; i < KSIZE; i++) begin : g_cell
        logic [COL_VEC_BITS-1:0] cell_in;

        for (genvar k = 0; k < KSIZE; k++) begin : g_tap
            assign cell_taps[i][k*COEF_BITS +: COEF_BITS] =
                coef_ext[k][i*TAP_SLOT +: COEF_BITS];
        end

        if (i == KSIZE - 1) begin : g_head
            assign cell_in = cur_col;
        end else begin : g_body
            assign cell_in = col_link[i+1];
        end

        c2d_cell #(
            .PIXEL_BITS (PIXEL_BITS),
            .COEF_BITS  (COEF_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .col_in  (cell_in),
            .taps    (cell_taps[i]),
            .col_out (col_link[i]),
            .col_sum (col_sum[i])
        );
    end

    // ---------------- tag pipeline alongside the cells ----------------
    // win: window loaded, prod: products registered, cs: column sums registered
    logic win_valid_reg, win_last_reg;
    logic prod_valid_reg, prod_last_reg;
    logic cs_valid_reg, cs_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            cs_valid_reg   <= 1'b0;
        end else if (advance) begin
            win_valid_reg  <= s1_valid_reg && s1_emit_reg;
            prod_valid_reg <= win_valid_reg;
            cs_valid_reg   <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            win_last_reg  <= s1_last_reg;
            prod_last_reg <= win_last_reg;
            cs_last_reg   <= prod_last_reg;
        end
    end

    // ---------------- output register ----------------
    logic                       m_tvalid_reg, m_tlast_reg;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < KSIZE; i++) begin
            sum_next = sum_next + col_sum[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= cs_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tlast_reg <= cs_last_reg;
            sum_reg     <= sum_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_DATA_BITS'($unsigned(sum_reg));

    // ---------------- assertions ----------------
    `C2D_ASSERT_IMPL(a_out_from_sums, aclk, aresetn, $rose(m_tvalid_reg), $past(cs_valid_reg), "result shown without a column sum behind it")
    `C2D_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, in_accept && line_end && frame_end, col_reg == '0 && row_reg == '0, "position did not wrap at frame end")
    `C2D_ASSERT_NEXT(a_store_bypass, aclk, aresetn, in_accept && wr_en && s1_col_reg == col_acc, byp_reg, "row store hazard not bypassed")

endmodule
